FILE: sv/lbsf_pkg.sv
// Shared types and constants for the balance state-feedback core.
// Holds the sequencer state codes, register indexes, operation codes and
// the fixed-point constants of the sine polynomial. No dependencies.
`default_nettype none

package lbsf_pkg;

	// Stream payload widths
	localparam int InDataW  = 80;
	localparam int OutDataW = 32;

	// Configuration port
	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 32;

	// Datapath widths
	localparam int MulW   = 33;  // signed operand width of the shared multiplier
	localparam int ProdW  = 2 * MulW;
	localparam int PhaseW = 36;  // signed Q30 angle during range reduction
	localparam int AccW   = 52;  // signed sum of the feedback terms in Q16
	localparam int DriveW = 16;

	// Angle constants in Q30
	localparam logic signed [PhaseW-1:0] TwoPiQ30  = 36'sd6746518852;
	localparam logic signed [PhaseW-1:0] PiQ30     = 36'sd3373259426;
	localparam logic signed [PhaseW-1:0] HalfPiQ30 = 36'sd1686629713;

	// Horner seed: 1/39916800 in Q30
	localparam logic [31:0] HornerSeed = 32'd27;

	// Largest drive magnitude
	localparam logic [DriveW-2:0] DriveMax = 15'd32767;

	// Register reset values
	localparam logic [31:0] GainAngleRst    = 32'hFF6A_0000;  // -150.0
	localparam logic [31:0] GainRateRst     = 32'hFFE7_0000;  // -25.0
	localparam logic [31:0] GainSpeedRst    = 32'hFFF8_0000;  // -8.0
	localparam logic [31:0] GainIntegralRst = 32'hFFFF_8000;  // -0.5
	localparam logic [31:0] GainGravityRst  = 32'h0032_0000;  // 50.0
	localparam logic [15:0] TiltOffsetRst   = 16'h0000;
	localparam logic [30:0] IntegralBndRst  = 31'd32768000;   // 500.0
	localparam logic [23:0] StepPeriodRst   = 24'd16777;      // about 1 ms

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_ANGLE    = 4'd0,
		REG_GAIN_RATE     = 4'd1,
		REG_GAIN_SPEED    = 4'd2,
		REG_GAIN_INTEGRAL = 4'd3,
		REG_GAIN_GRAVITY  = 4'd4,
		REG_TILT_OFFSET   = 4'd5,
		REG_INTEGRAL_BND  = 4'd6,
		REG_STEP_PERIOD   = 4'd7
	} lbsf_reg_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_POST   = 5'b01000,
		ST_ROUND  = 5'b10000
	} lbsf_state_t;

	// Operations of the shared multiplier, in issue order
	typedef enum logic [3:0] {
		OP_SQUARE   = 4'd0,
		OP_HORNER1  = 4'd1,
		OP_HORNER2  = 4'd2,
		OP_HORNER3  = 4'd3,
		OP_HORNER4  = 4'd4,
		OP_HORNER5  = 4'd5,
		OP_SINE     = 4'd6,
		OP_INTEGRAL = 4'd7,
		OP_ANGLE    = 4'd8,
		OP_RATE     = 4'd9,
		OP_SPEED    = 4'd10,
		OP_INT_GAIN = 4'd11,
		OP_GRAVITY  = 4'd12
	} lbsf_op_t;

	// Horner coefficient from which the product is subtracted at each polynomial step (Q30)
	function automatic logic [31:0] horner_coef(input lbsf_op_t op);
		logic [31:0] c;
		begin
			c = 32'd0;
			unique case (op)
				OP_HORNER1: c = 32'd2959;
				OP_HORNER2: c = 32'd213044;
				OP_HORNER3: c = 32'd8947849;
				OP_HORNER4: c = 32'd178956971;
				OP_HORNER5: c = 32'd1073741824;
				default:    c = 32'd0;
			endcase
			return c;
		end
	endfunction

endpackage

`default_nettype wire

FILE: sv/lqr_balance_state_feedback_core.sv
// Balance controller core: state feedback with speed integral and gravity feed-forward.
// One shared 33x33 multiplier under a small sequencer; depends on lbsf_pkg.
`default_nettype none

// Usage
//  s_axis: one sensor sample per request. tdata carries pitch_angle, pitch_rate,
//  left_wheel_speed, right_wheel_speed and speed_setpoint (16 bits each, lowest first);
//  tuser[0] is clear_integral, which zeroes the speed integral before the sample.
//  m_axis: one drive request per sample, left_drive in tdata[15:0] and
//  right_drive (its negation) in tdata[31:16], both saturated to +/-32767.
//  cfg: write-only register port, always ready; write only while the core is idle.
//  Indexes outside 0..7 are ignored.
//  Sequence: a sample request goes through the angle reduction, then thirteen
//  products go through the single multiplier, each in a multiply state and a
//  post state, then the rounding state loads the drive request. A new sample
//  is taken only once the sequencer is back in idle.
//  s_axis_tready is high only while the sequencer is idle.
//  The drive request sits in an output register, so a new sample is taken while
//  it waits; a stalled receiver holds the sequencer in its rounding cycle
//  until the register frees up.
//  Reset: gains return to their defaults, the speed integral clears and no
//  request is pending.
module lqr_balance_state_feedback_core
	import lbsf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// sample input
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// pitch_angle, pitch_rate, left_wheel_speed, right_wheel_speed, speed_setpoint
	input  wire logic [InDataW-1:0]  s_axis_tdata,
	// clear_integral
	input  wire logic [0:0]          s_axis_tuser,
	// drive output
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// left_drive, right_drive
	output logic [OutDataW-1:0]      m_axis_tdata,
	// register writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	// Configuration registers
	logic signed [31:0] gain_angle_q;
	logic signed [31:0] gain_rate_q;
	logic signed [31:0] gain_speed_q;
	logic signed [31:0] gain_integral_q;
	logic signed [31:0] gain_gravity_q;
	logic signed [15:0] tilt_offset_q;
	logic [30:0]        integral_bound_q;
	logic [23:0]        step_period_q;

	// Control state
	lbsf_state_t        state_q;
	lbsf_op_t           op_q;
	logic signed [31:0] speed_integral_q;
	logic               out_valid_q;

	// Per-sample payload
	logic signed [16:0]       angle_q;
	logic signed [15:0]       rate_q;
	logic signed [17:0]       err_q;
	logic signed [PhaseW-1:0] phase_q;
	logic                     sin_neg_q;
	logic [30:0]              mag_q;
	logic [31:0]              x2_q;
	logic [31:0]              poly_q;
	logic signed [31:0]       sine_q;
	logic signed [AccW-1:0]   u_q;
	logic signed [ProdW-1:0]  prod_q;
	logic [OutDataW-1:0]      out_data_q;

	// Input unpacking
	logic signed [15:0] in_pitch;
	logic signed [15:0] in_rate;
	logic signed [15:0] in_left;
	logic signed [15:0] in_right;
	logic signed [15:0] in_setpoint;
	logic signed [16:0] in_angle;
	logic signed [17:0] in_err;
	logic               in_accept;

	assign in_pitch    = s_axis_tdata[15:0];
	assign in_rate     = s_axis_tdata[31:16];
	assign in_left     = s_axis_tdata[47:32];
	assign in_right    = s_axis_tdata[63:48];
	assign in_setpoint = s_axis_tdata[79:64];

	assign in_angle  = {in_pitch[15], in_pitch} - {tilt_offset_q[15], tilt_offset_q};
	assign in_err    = {{2{in_left[15]}}, in_left} + {{2{in_right[15]}}, in_right}
	                 - {in_setpoint[15], in_setpoint, 1'b0};
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Fold the reduced angle into [-pi/2, pi/2] and take its magnitude
	logic signed [PhaseW-1:0] phase_fold;
	logic signed [PhaseW-1:0] phase_abs;

	always_comb begin
		priority if (phase_q > HalfPiQ30) begin
			phase_fold = PiQ30 - phase_q;
		end else if (phase_q < -HalfPiQ30) begin
			phase_fold = -PiQ30 - phase_q;
		end else begin
			phase_fold = phase_q;
		end
		phase_abs = phase_fold[PhaseW-1] ? -phase_fold : phase_fold;
	end

	// Operand selection for the shared multiplier
	logic signed [MulW-1:0] mul_a;
	logic signed [MulW-1:0] mul_b;

	always_comb begin
		unique case (op_q)
			OP_SQUARE: begin
				mul_a = {2'b00, mag_q};
				mul_b = {2'b00, mag_q};
			end
			OP_HORNER1, OP_HORNER2, OP_HORNER3, OP_HORNER4, OP_HORNER5: begin
				mul_a = {1'b0, x2_q};
				mul_b = {1'b0, poly_q};
			end
			OP_SINE: begin
				mul_a = {2'b00, mag_q};
				mul_b = {1'b0, poly_q};
			end
			OP_INTEGRAL: begin
				mul_a = {{(MulW-18){err_q[17]}}, err_q};
				mul_b = {{(MulW-24){1'b0}}, step_period_q};
			end
			OP_ANGLE: begin
				mul_a = {gain_angle_q[31], gain_angle_q};
				mul_b = {{(MulW-17){angle_q[16]}}, angle_q};
			end
			OP_RATE: begin
				mul_a = {gain_rate_q[31], gain_rate_q};
				mul_b = {{(MulW-16){rate_q[15]}}, rate_q};
			end
			OP_SPEED: begin
				mul_a = {gain_speed_q[31], gain_speed_q};
				mul_b = {{(MulW-18){err_q[17]}}, err_q};
			end
			OP_INT_GAIN: begin
				mul_a = {gain_integral_q[31], gain_integral_q};
				mul_b = {speed_integral_q[31], speed_integral_q};
			end
			OP_GRAVITY: begin
				mul_a = {gain_gravity_q[31], gain_gravity_q};
				mul_b = {sine_q[31], sine_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Floor-shift the registered product by the operation's scale
	logic signed [ProdW-1:0] prod_sh;

	always_comb begin
		unique case (op_q)
			OP_INTEGRAL: prod_sh = prod_q >>> 13;
			OP_ANGLE:    prod_sh = prod_q >>> 12;
			OP_RATE:     prod_sh = prod_q >>> 8;
			OP_SPEED:    prod_sh = prod_q >>> 5;
			OP_INT_GAIN: prod_sh = prod_q >>> 16;
			default:     prod_sh = prod_q >>> 30;
		endcase
	end

	// Speed integral update with symmetric clamp
	logic signed [33:0] integ_sum;
	logic signed [33:0] integ_bnd;
	logic signed [31:0] integ_next;

	assign integ_sum = {{2{speed_integral_q[31]}}, speed_integral_q} + prod_sh[33:0];
	assign integ_bnd = {3'b000, integral_bound_q};

	always_comb begin
		priority if (integ_sum > integ_bnd) begin
			integ_next = integ_bnd[31:0];
		end else if (integ_sum < -integ_bnd) begin
			integ_next = 32'(-integ_bnd);
		end else begin
			integ_next = integ_sum[31:0];
		end
	end

	// Horner step and sign restore of the sine
	logic [31:0] horner_next;
	logic [31:0] sine_mag;

	assign horner_next = horner_coef(op_q) - prod_sh[31:0];
	assign sine_mag    = prod_sh[31:0];

	// Round half away from zero and saturate
	logic signed [AccW-1:0] u_abs;
	logic [AccW-1:0]        u_round;
	logic [DriveW-2:0]      drive_mag;
	logic signed [DriveW-1:0] drive_left;
	logic signed [DriveW-1:0] drive_right;
	logic                   out_load;

	always_comb begin
		u_abs   = u_q[AccW-1] ? -u_q : u_q;
		u_round = AccW'(u_abs) + AccW'(32768);
		if (u_round[AccW-1:16] > {{(AccW-16-(DriveW-1)){1'b0}}, DriveMax}) begin
			drive_mag = DriveMax;
		end else begin
			drive_mag = u_round[16+DriveW-2:16];
		end
		drive_left  = u_q[AccW-1] ? -{1'b0, drive_mag} : {1'b0, drive_mag};
		drive_right = -drive_left;
	end

	assign out_load = (state_q == ST_ROUND) && (!out_valid_q || m_axis_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_angle_q     <= GainAngleRst;
			gain_rate_q      <= GainRateRst;
			gain_speed_q     <= GainSpeedRst;
			gain_integral_q  <= GainIntegralRst;
			gain_gravity_q   <= GainGravityRst;
			tilt_offset_q    <= TiltOffsetRst;
			integral_bound_q <= IntegralBndRst;
			step_period_q    <= StepPeriodRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lbsf_reg_t'(cfg_index))
				REG_GAIN_ANGLE:    gain_angle_q     <= cfg_data;
				REG_GAIN_RATE:     gain_rate_q      <= cfg_data;
				REG_GAIN_SPEED:    gain_speed_q     <= cfg_data;
				REG_GAIN_INTEGRAL: gain_integral_q  <= cfg_data;
				REG_GAIN_GRAVITY:  gain_gravity_q   <= cfg_data;
				REG_TILT_OFFSET:   tilt_offset_q    <= cfg_data[15:0];
				REG_INTEGRAL_BND:  integral_bound_q <= cfg_data[30:0];
				REG_STEP_PERIOD:   step_period_q    <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, integral state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			op_q             <= OP_SQUARE;
			speed_integral_q <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			// raise the output request on load, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (s_axis_tuser[0]) begin
							speed_integral_q <= '0;
						end
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (phase_q <= PiQ30 && phase_q >= -PiQ30) begin
						op_q    <= OP_SQUARE;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (op_q == OP_INTEGRAL) begin
						speed_integral_q <= integ_next;
					end
					if (op_q == OP_GRAVITY) begin
						state_q <= ST_ROUND;
					end else begin
						op_q    <= lbsf_op_t'(op_q + 4'd1);
						state_q <= ST_MUL;
					end
				end
				ST_ROUND: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// latch the sample
		if (in_accept) begin
			angle_q <= in_angle;
			rate_q  <= in_rate;
			err_q   <= in_err;
			phase_q <= {in_angle[16], in_angle, 18'b0};
		end

		// bring the angle into [-pi, pi], then fold and seed the polynomial
		if (state_q == ST_REDUCE) begin
			priority if (phase_q > PiQ30) begin
				phase_q <= phase_q - TwoPiQ30;
			end else if (phase_q < -PiQ30) begin
				phase_q <= phase_q + TwoPiQ30;
			end else begin
				sin_neg_q <= phase_fold[PhaseW-1];
				mag_q     <= phase_abs[30:0];
				poly_q    <= HornerSeed;
			end
		end

		// shared multiplier
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
		end

		// consume the product
		if (state_q == ST_POST) begin
			unique case (op_q)
				OP_SQUARE: x2_q <= prod_sh[31:0];
				OP_HORNER1, OP_HORNER2, OP_HORNER3, OP_HORNER4, OP_HORNER5:
					poly_q <= horner_next;
				OP_SINE: sine_q <= sin_neg_q ? -sine_mag : sine_mag;
				OP_ANGLE: u_q <= prod_sh[AccW-1:0];
				OP_RATE, OP_SPEED, OP_INT_GAIN: u_q <= u_q + prod_sh[AccW-1:0];
				OP_GRAVITY: u_q <= prod_sh[AccW-1:0] - u_q;
				default: begin
				end
			endcase
		end

		// hold the drive request
		if (out_load) begin
			out_data_q <= {drive_right, drive_left};
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_lqr_balance_state_feedback_core.sv
// Self-checking testbench for lqr_balance_state_feedback_core.
// A directed table and randomised samples go through the sample stream under
// several register settings. Each drive request is checked against a typed pair
// or a local predictor. Depends on lbsf_pkg and the core.
`timescale 1ns / 100ps

module tb_lqr_balance_state_feedback_core;
	import lbsf_pkg::*;

	localparam int ClkPeriod  = 8;
	localparam int ResetLen   = 10;
	localparam int CycleLimit = 600000;
	localparam int SettleLen  = 40;
	localparam int DirRows    = 22;
	localparam int PhaseItems = 110;

	// Predictor constants: angles in Q30, sine coefficients in Q30
	localparam longint TwoPiFix  = 64'sd6746518852;
	localparam longint PiFix     = 64'sd3373259426;
	localparam longint HalfPiFix = 64'sd1686629713;
	localparam logic [63:0] SinOne = 64'd1073741824;
	localparam logic [63:0] SinC3  = 64'd178956971;
	localparam logic [63:0] SinC5  = 64'd8947849;
	localparam logic [63:0] SinC7  = 64'd213044;
	localparam logic [63:0] SinC9  = 64'd2959;
	localparam logic [63:0] SinC11 = 64'd27;
	localparam longint DriveLimit = 64'sd32767;

	localparam logic [CfgIdxW-1:0] FirstSpareReg = CfgIdxW'(REG_STEP_PERIOD) + 1'b1;

	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] rate;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic signed [15:0] setpoint;
		logic               clr;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} drive_t;

	typedef struct packed {
		sample_t smp;
		logic    typed;
		drive_t  want;
	} dir_row_t;

	typedef enum int {SET_TOP, SET_BOTTOM, SET_NARROW, SET_WIDE} set_kind_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic [0:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// Predictor copy of the registers and the speed integral
	logic signed [31:0] k_angle, k_rate, k_speed, k_integral, k_gravity;
	logic signed [15:0] tilt_q12;
	logic        [30:0] bound_q16;
	logic        [23:0] period_q24;
	logic signed [31:0] integ_q16;

	drive_t   drives_due[$];
	drive_t   seen_want;
	dir_row_t dir_tab[DirRows];
	int       mismatches = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	bit       quiet = 1'b0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_run = 0;
	bit       rx_level = 1'b0;

	lqr_balance_state_feedback_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// Sine of a Q3.12 angle in Q30: reduce, fold, odd Taylor series by Horner
	function automatic longint sine_q30(input longint ang);
		longint      x;
		logic [63:0] m, x2, t;
		logic        neg;
		x = ang * 64'sd262144;
		while (x > PiFix) x = x - TwoPiFix;
		while (x < -PiFix) x = x + TwoPiFix;
		if (x > HalfPiFix) x = PiFix - x;
		if (x < -HalfPiFix) x = -PiFix - x;
		neg = (x < 0);
		m = neg ? 64'(-x) : 64'(x);
		x2 = (m * m) >> 30;
		t = SinC11;
		t = SinC9 - ((x2 * t) >> 30);
		t = SinC7 - ((x2 * t) >> 30);
		t = SinC5 - ((x2 * t) >> 30);
		t = SinC3 - ((x2 * t) >> 30);
		t = SinOne - ((x2 * t) >> 30);
		t = (m * t) >> 30;
		return neg ? -longint'(t) : longint'(t);
	endfunction

	// Advance the integral and work out the drive pair for one sample
	task automatic compute_drive(input sample_t s, output drive_t d);
		longint ang, err, acc, bnd, grav, fb, u, mag, r;
		ang = longint'(s.angle) - longint'(tilt_q12);
		err = longint'(s.left) + longint'(s.right) - 2 * longint'(s.setpoint);
		if (s.clr)
			integ_q16 = '0;
		acc = longint'(integ_q16) + ((err * longint'({1'b0, period_q24})) >>> 13);
		bnd = longint'({1'b0, bound_q16});
		if (acc > bnd)
			acc = bnd;
		if (acc < -bnd)
			acc = -bnd;
		integ_q16 = 32'(acc);
		fb = ((longint'(k_angle) * ang) >>> 12)
		   + ((longint'(k_rate) * longint'(s.rate)) >>> 8)
		   + ((longint'(k_speed) * err) >>> 5)
		   + ((longint'(k_integral) * longint'(integ_q16)) >>> 16);
		grav = (longint'(k_gravity) * sine_q30(ang)) >>> 30;
		u = grav - fb;
		mag = (u < 0) ? -u : u;
		r = (mag + 64'sd32768) >>> 16;
		if (r > DriveLimit)
			r = DriveLimit;
		if (u < 0)
			r = -r;
		d.left = 16'(r);
		d.right = 16'(-r);
	endtask

	function automatic sample_t mk(input int a, input int g, input int l, input int r,
		input int sp, input bit c);
		sample_t s;
		s.angle = 16'(a);
		s.rate = 16'(g);
		s.left = 16'(l);
		s.right = 16'(r);
		s.setpoint = 16'(sp);
		s.clr = c;
		return s;
	endfunction

	// Mostly modest magnitudes, with full-range words a quarter of the time
	function automatic logic signed [15:0] rand_field();
		logic signed [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(0, 3) != 0)
			v = v >>> $urandom_range(2, 13);
		return v;
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.angle = rand_field();
		s.rate = rand_field();
		s.left = rand_field();
		s.right = rand_field();
		s.setpoint = rand_field();
		s.clr = ($urandom_range(0, 15) == 0);
		return s;
	endfunction

	function automatic logic [31:0] pick_gain(input set_kind_t kind);
		logic signed [31:0] v;
		case (kind)
			SET_TOP:    v = 32'sh7FFF_FFFF;
			SET_BOTTOM: v = 32'sh8000_0000;
			default: begin
				v = 32'($urandom);
				v = v >>> (32 - $urandom_range(8, 28));
			end
		endcase
		return v;
	endfunction

	// Send one sample request; queue the typed or the predicted drive pair
	task automatic push_sample(input sample_t s, input bit typed, input drive_t want);
		drive_t d;
		int     gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {s.setpoint, s.right, s.left, s.rate, s.angle};
		s_axis_tuser <= s.clr;
		do @(posedge clk); while (!s_axis_tready);
		compute_drive(s, d);
		drives_due.push_back(typed ? want : d);
	endtask

	// Drop the sample request and hold until every drive request has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (drives_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_ANGLE:    k_angle = val;
			REG_GAIN_RATE:     k_rate = val;
			REG_GAIN_SPEED:    k_speed = val;
			REG_GAIN_INTEGRAL: k_integral = val;
			REG_GAIN_GRAVITY:  k_gravity = val;
			REG_TILT_OFFSET:   tilt_q12 = val[15:0];
			REG_INTEGRAL_BND:  bound_q16 = val[30:0];
			REG_STEP_PERIOD:   period_q24 = val[23:0];
			default: ;
		endcase
	endtask

	// Program every register; unused upper bits carry junk that must be dropped
	task automatic program_set(input set_kind_t kind);
		logic [15:0] tilt;
		logic [30:0] bnd;
		logic [23:0] per;
		case (kind)
			SET_TOP: begin
				tilt = 16'h7FFF;
				bnd = 31'h7FFF_FFFF;
				per = 24'hFF_FFFF;
			end
			SET_BOTTOM: begin
				tilt = 16'h8000;
				bnd = '0;
				per = '0;
			end
			SET_NARROW: begin
				tilt = rand_field() >>> 4;
				bnd = 31'($urandom_range(0, 1 << 20));
				per = 24'($urandom);
			end
			default: begin
				tilt = rand_field() >>> 2;
				bnd = 31'($urandom >> $urandom_range(1, 16));
				per = ($urandom_range(0, 3) == 0) ? '0 : 24'($urandom_range(1, 24'hFF_FFFF));
			end
		endcase
		write_reg(REG_GAIN_ANGLE, pick_gain(kind));
		write_reg(REG_GAIN_RATE, pick_gain(kind));
		write_reg(REG_GAIN_SPEED, pick_gain(kind));
		write_reg(REG_GAIN_INTEGRAL, pick_gain(kind));
		write_reg(REG_GAIN_GRAVITY, pick_gain(kind));
		write_reg(REG_TILT_OFFSET, {16'($urandom), tilt});
		write_reg(REG_INTEGRAL_BND, {1'($urandom), bnd});
		write_reg(REG_STEP_PERIOD, {8'($urandom), per});
		// an index past the register file must change nothing
		write_reg(CfgIdxW'($urandom_range(FirstSpareReg, (1 << CfgIdxW) - 1)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input set_kind_t kind, input int count);
		program_set(kind);
		quiet = ($urandom_range(0, 3) == 0);
		burst_left = 0;
		repeat (count) push_sample(rand_sample(), 1'b0, '0);
		drain();
	endtask

	// Directed rows: zero sample, speed saturation both ways, angle wrap and fold,
	// rate extremes, integral build-up and clearing, alternating bit patterns
	task automatic load_directed();
		dir_tab[0]  = '{mk(0, 0, 0, 0, 0, 1'b0), 1'b1, '{16'sd0, 16'sd0}};
		dir_tab[1]  = '{mk(0, 0, 32767, 32767, -32768, 1'b1), 1'b1, '{16'sd32767, -16'sd32767}};
		dir_tab[2]  = '{mk(0, 0, -32768, -32768, 32767, 1'b1), 1'b1, '{-16'sd32767, 16'sd32767}};
		dir_tab[3]  = '{mk(32767, 0, 0, 0, 0, 1'b1), 1'b0, '0};
		dir_tab[4]  = '{mk(-32768, 0, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[5]  = '{mk(0, 32767, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[6]  = '{mk(0, -32768, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[7]  = '{mk(6434, 0, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[8]  = '{mk(-6434, 0, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[9]  = '{mk(12868, 0, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[10] = '{mk(-12868, 0, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[11] = '{mk(25736, -1, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[12] = '{mk(0, 0, 32767, 32767, -32768, 1'b0), 1'b0, '0};
		dir_tab[13] = '{mk(0, 0, 32767, 32767, -32768, 1'b0), 1'b0, '0};
		dir_tab[14] = '{mk(0, 0, 32767, 32767, -32768, 1'b0), 1'b0, '0};
		dir_tab[15] = '{mk(100, 200, 300, -300, 16, 1'b1), 1'b0, '0};
		dir_tab[16] = '{mk(-1, -1, -1, -1, -1, 1'b0), 1'b0, '0};
		dir_tab[17] = '{mk(21845, -21846, 21845, -21846, 21845, 1'b1), 1'b0, '0};
		dir_tab[18] = '{mk(-21846, 21845, -21846, 21845, -21846, 1'b0), 1'b0, '0};
		dir_tab[19] = '{mk(0, 0, 1, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[20] = '{mk(1, 1, 0, 0, 0, 1'b0), 1'b0, '0};
		dir_tab[21] = '{mk(-20000, 5000, -700, 900, -40, 1'b0), 1'b0, '0};
	endtask

	// Receiver stall pattern: a mode is held for a while, then redrawn
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(50, 400);
		end
		rx_mode_left--;
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_run == 0) begin
					rx_level = !rx_level;
					rx_run = rx_level ? $urandom_range(1, 4) : $urandom_range(10, 60);
				end
				rx_run--;
				m_axis_tready <= rx_level;
			end
		endcase
	end

	// Check each drive request against the oldest queued expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drives_due.size() == 0) begin
				$error("unexpected drive request: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				seen_want = drives_due.pop_front();
				if (m_axis_tdata[15:0] !== seen_want.left) begin
					$error("left_drive: expected %0d, got %0d", seen_want.left,
						$signed(m_axis_tdata[15:0]));
					mismatches++;
				end
				if (m_axis_tdata[31:16] !== seen_want.right) begin
					$error("right_drive: expected %0d, got %0d", seen_want.right,
						$signed(m_axis_tdata[31:16]));
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int p;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// register defaults and a cleared integral, as after reset
		k_angle = -32'sd9830400;
		k_rate = -32'sd1638400;
		k_speed = -32'sd524288;
		k_integral = -32'sd32768;
		k_gravity = 32'sd3276800;
		tilt_q12 = '0;
		bound_q16 = 31'd32768000;
		period_q24 = 24'd16777;
		integ_q16 = '0;
		load_directed();

		repeat (ResetLen) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset settings
		for (p = 0; p < DirRows; p++)
			push_sample(dir_tab[p].smp, dir_tab[p].typed, dir_tab[p].want);
		drain();

		// top extremes, then a lowered bound on a built-up integral, bottom extremes, then randomised sets
		run_phase(SET_TOP, 80);
		run_phase(SET_NARROW, PhaseItems);
		run_phase(SET_BOTTOM, 80);
		for (p = 0; p < 7; p++)
			run_phase((p % 3 == 0) ? SET_NARROW : SET_WIDE, PhaseItems);

		repeat (SettleLen) @(posedge clk);
		if (mismatches == 0 && drives_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
